// File: rtl/core/ipf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix filter package
// Shared command and status codes, the stored entry layout and the
// compare unit result.
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_DUPLICATE  = 3'd1;
    localparam logic [2:0] STS_FULL       = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND  = 3'd3;
    localparam logic [2:0] STS_BAD_PREFIX = 3'd4;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    // One stored filter; addresses are kept normalised (IPv4 upper bits zero)
    typedef struct packed {
        logic        family;
        logic [7:0]  prefix;
        logic [63:0] addr_upper;
        logic [63:0] addr_lower;
    } ipf_entry_t;

    localparam int ENTRY_W = $bits(ipf_entry_t);

    typedef struct packed {
        logic hit;   // same family and equal under the entry's prefix mask
        logic same;  // same family, prefix and full address
    } ipf_cmp_t;

endpackage

// File: rtl/core/ip_prefix_allow_block_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix allow/block filter core
// Two CIDR tables (allow, block) of ENTRIES slots in one RAM, scanned one
// slot per cycle through a single compare unit.
// ----------------------------------------------------------------------------
// An add scans the selected list, a check the block list and then the allow
// list; remove, clear and an add with a bad prefix go straight to the result.
// One item at a time; the RAM read port and the compare unit take one slot a
// cycle. A new item is taken as soon as the sequencer is idle, while a result
// still waits in the output register.
// Reset clears the valid bits at once; entry storage is not cleared.
module ip_prefix_allow_block_filter_core
    import ipf_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0], list_sel[2], is_ipv6[3], address_upper[67:4],
    // address_lower[131:68], prefix_length[139:132], entry_index[143:140]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], allowed[3], slot_out[7:4]
    output logic [7:0]   m_tdata
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = SW + 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t        state_reg;
    logic [ENTRIES-1:0] valid_reg [0:1];

    // latched command
    logic [1:0]    cmd_reg;
    logic          lsel_reg;
    logic          fam_reg;
    logic [63:0]   au_reg;
    logic [63:0]   al_reg;
    logic [7:0]    plen_reg;
    logic [3:0]    idx_reg;

    // sequencer
    logic          bad_prefix_reg;
    logic          list_reg;
    logic [SW-1:0] slot_reg;
    logic          issue_done_reg;
    logic          rd_vld_reg;
    logic          rd_list_reg;
    logic [SW-1:0] rd_slot_reg;
    logic          dup_reg;
    logic          free_found_reg;
    logic [SW-1:0] free_slot_reg;
    logic          blk_hit_reg;
    logic          alw_hit_reg;

    logic [2:0]    status_reg;
    logic          allowed_reg;
    logic [3:0]    slot_out_reg;
    logic          m_tvalid_reg;

    logic [2:0]    status_next;
    logic          allowed_next;
    logic [3:0]    slot_out_next;

    logic          in_acc;
    logic          out_free;
    logic          res_load;
    logic          in_fam;
    logic [7:0]    in_plen;
    logic          ram_we;
    logic          ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    ipf_entry_t    wr_entry;
    ipf_entry_t    rd_entry;
    ipf_cmp_t      cmp_res;
    logic          idx_ok;
    logic [SW-1:0] idx_slot;
    logic          rm_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign res_load = (state_reg == ST_FINISH) && out_free;
    assign in_fam   = s_tdata[3];
    assign in_plen  = s_tdata[139:132];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {slot_out_reg, allowed_reg, status_reg};

    assign idx_ok   = (32'(idx_reg) < ENTRIES);
    assign idx_slot = SW'(idx_reg);
    assign rm_ok    = idx_ok && valid_reg[lsel_reg][idx_slot];

    assign wr_entry.family     = fam_reg;
    assign wr_entry.prefix     = plen_reg;
    assign wr_entry.addr_upper = au_reg;
    assign wr_entry.addr_lower = al_reg;
    assign rd_entry            = ram_rdata;

    assign ram_re = (state_reg == ST_SCAN) && !issue_done_reg;
    assign ram_we = (state_reg == ST_FINISH) && out_free && (cmd_reg == CMD_ADD)
                    && !bad_prefix_reg && !dup_reg && free_found_reg;

    ipf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({lsel_reg, free_slot_reg}),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr ({list_reg, slot_reg}),
        .rdata (ram_rdata)
    );

    ipf_cmp u_cmp (
        .entry      (rd_entry),
        .family     (fam_reg),
        .prefix     (plen_reg),
        .addr_upper (au_reg),
        .addr_lower (al_reg),
        .result     (cmp_res)
    );

    // Result fields of the finished command
    always_comb
    begin
        status_next   = STS_OK;
        allowed_next  = 1'b0;
        slot_out_next = '0;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (bad_prefix_reg)
                begin
                    status_next = STS_BAD_PREFIX;
                end
                else if (dup_reg)
                begin
                    status_next = STS_DUPLICATE;
                end
                else if (!free_found_reg)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    slot_out_next = 4'(free_slot_reg);
                end
            end
            CMD_REMOVE:
            begin
                if (!rm_ok)
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            CMD_CHECK:
            begin
                allowed_next = !blk_hit_reg || alw_hit_reg;
            end
            CMD_CLEAR:
            begin
                status_next = STS_OK;
            end
            default:
            begin
                status_next = STS_OK;
            end
        endcase
    end

    // Latch the command; normalise IPv4 addresses
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= s_tdata[1:0];
            lsel_reg <= s_tdata[2];
            fam_reg  <= in_fam;
            au_reg   <= in_fam ? s_tdata[67:4] : 64'd0;
            al_reg   <= in_fam ? s_tdata[131:68] : {32'd0, s_tdata[99:68]};
            plen_reg <= in_plen;
            idx_reg  <= s_tdata[143:140];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg[0]   <= '0;
            valid_reg[1]   <= '0;
            bad_prefix_reg <= 1'b0;
            list_reg       <= 1'b0;
            slot_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_list_reg    <= 1'b0;
            rd_slot_reg    <= '0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            blk_hit_reg    <= 1'b0;
            alw_hit_reg    <= 1'b0;
            status_reg     <= STS_OK;
            allowed_reg    <= 1'b0;
            slot_out_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                m_tvalid_reg <= 1'b1;
                status_reg   <= status_next;
                allowed_reg  <= allowed_next;
                slot_out_reg <= slot_out_next;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        bad_prefix_reg <= in_fam ? (in_plen > V6_MAX_PREFIX)
                                                 : (in_plen > V4_MAX_PREFIX);
                        // check scans the block list first, then the allow list
                        list_reg       <= (s_tdata[1:0] == CMD_CHECK) ? 1'b1 : s_tdata[2];
                        slot_reg       <= '0;
                        issue_done_reg <= 1'b0;
                        rd_vld_reg     <= 1'b0;
                        dup_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        blk_hit_reg    <= 1'b0;
                        alw_hit_reg    <= 1'b0;
                        if ((s_tdata[1:0] == CMD_CHECK) ||
                            ((s_tdata[1:0] == CMD_ADD) &&
                             !(in_fam ? (in_plen > V6_MAX_PREFIX)
                                      : (in_plen > V4_MAX_PREFIX))))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (!issue_done_reg)
                    begin
                        rd_vld_reg  <= 1'b1;
                        rd_list_reg <= list_reg;
                        rd_slot_reg <= slot_reg;
                        if (slot_reg == SLOT_LAST)
                        begin
                            slot_reg <= '0;
                            if ((cmd_reg == CMD_CHECK) && list_reg)
                            begin
                                list_reg <= 1'b0;
                            end
                            else
                            begin
                                issue_done_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b0;
                    end

                    if (rd_vld_reg)
                    begin
                        if (valid_reg[rd_list_reg][rd_slot_reg])
                        begin
                            if (cmp_res.same)
                            begin
                                dup_reg <= 1'b1;
                            end
                            if (cmp_res.hit)
                            begin
                                if (rd_list_reg)
                                begin
                                    blk_hit_reg <= 1'b1;
                                end
                                else
                                begin
                                    alw_hit_reg <= 1'b1;
                                end
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_slot_reg  <= rd_slot_reg;
                        end
                    end

                    if (issue_done_reg && !rd_vld_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (ram_we)
                        begin
                            valid_reg[lsel_reg][free_slot_reg] <= 1'b1;
                        end
                        else if ((cmd_reg == CMD_REMOVE) && rm_ok)
                        begin
                            valid_reg[lsel_reg][idx_slot] <= 1'b0;
                        end
                        else if (cmd_reg == CMD_CLEAR)
                        begin
                            valid_reg[0] <= '0;
                            valid_reg[1] <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A result is only loaded from the final sequencer step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    // Never overwrite a slot that is in use
    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !valid_reg[lsel_reg][free_slot_reg])
        else $error("add wrote over a valid slot");

    // Read data returns only while scanning
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_SCAN))
        else $error("read data pending outside a scan");

    // Clear empties both lists
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free && cmd_reg == CMD_CLEAR)
        |=> (valid_reg[0] == '0 && valid_reg[1] == '0))
        else $error("clear left valid entries");

endmodule

// File: rtl/core/ipf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix filter RAM
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ipf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/ipf_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP prefix filter compare unit
// Compares one stored entry with the command's address under the entry's
// prefix mask, and checks for an identical entry.
// ----------------------------------------------------------------------------
module ipf_cmp
    import ipf_pkg::*;
(
    input  ipf_entry_t  entry,
    input  logic        family,
    input  logic [7:0]  prefix,
    input  logic [63:0] addr_upper,
    input  logic [63:0] addr_lower,
    output ipf_cmp_t    result
);

    logic [127:0] mask;
    logic [127:0] diff;
    logic [31:0]  mask_v4;
    logic         fam_eq;

    always_comb
    begin
        mask_v4 = ~(32'hFFFF_FFFF >> entry.prefix);
        if (entry.family)
        begin
            mask = ~({128{1'b1}} >> entry.prefix);
        end
        else
        begin
            mask = {96'd0, mask_v4};
        end
        diff   = {addr_upper, addr_lower} ^ {entry.addr_upper, entry.addr_lower};
        fam_eq = (entry.family == family);
        result.hit  = fam_eq && ((diff & mask) == '0);
        result.same = fam_eq && (entry.prefix == prefix) && (diff == '0);
    end

endmodule
